// ----- rtl/core/mm4_pkg.sv -----
package mm4_pkg;

  localparam int WORD_W         = 32;
  localparam int RES_W          = 16;
  localparam int DEF_MATRIX_DIM = 4;
  localparam int DEF_ELEM_BITS  = 8;

  // Control word: start bit on write, done flag on read.
  localparam logic [4:0]        CTRL_WORD_IDX  = 5'd0;
  localparam int               CTRL_START_BIT = 0;
  localparam logic [WORD_W-1:0] CTRL_DONE     = 32'h0000_0100;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Status from the multiply sequencer to the register front end.
  typedef struct packed {
    logic busy;
    logic wr_en;
  } seq_status_t;

endpackage

// ----- rtl/core/matrix_multiply_4x4_regs.sv -----
// Register-mapped matrix multiplier, C = A x B over unsigned packed elements.
// Input channel (in_valid/in_ready): one bus access per item, in_op selects
// read or write, in_word_index the word, in_write_data the written value.
// Word 0 is control (write bit 0 to start, read bit 8 for done), words 1..D
// hold the rows of A, D+1..2D the rows of B, and the following words read C
// as two 16-bit elements each.
// Result channel (out_valid/out_ready): one item per access, the read value,
// or zero for a write, registered and shown in the cycle after acceptance.
// Plain accesses run at one item per cycle while the result side keeps up.
// A start is answered at once, then a single shared multiply-accumulate unit
// runs D*D*D steps, one per cycle, and drains its operand, product and write
// registers; in_ready stays low until that pipeline is empty.
// While the receiver stalls, the result stays in the output register and
// in_ready drops, so no item is lost or repeated.
// Reset (rst_n low, synchronous) clears the rows, the done flag and the
// valid flags of the result words; C reads zero until the first multiply.
module matrix_multiply_4x4_regs #(
  parameter int MATRIX_DIM = mm4_pkg::DEF_MATRIX_DIM,
  parameter int ELEM_BITS  = mm4_pkg::DEF_ELEM_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic [4:0]                 in_word_index,
  input  logic [mm4_pkg::WORD_W-1:0] in_write_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mm4_pkg::WORD_W-1:0] out_read_data
);
  import mm4_pkg::*;

  localparam int IW      = $clog2(MATRIX_DIM);
  localparam int A_BASE  = 1;
  localparam int B_BASE  = A_BASE + MATRIX_DIM;
  localparam int C_BASE  = B_BASE + MATRIX_DIM;
  localparam int C_WORDS = (MATRIX_DIM * MATRIX_DIM + 1) / 2;
  localparam int CAW     = (C_WORDS > 1) ? $clog2(C_WORDS) : 1;

  logic [WORD_W-1:0] a_rows_r [MATRIX_DIM];
  logic [WORD_W-1:0] b_rows_r [MATRIX_DIM];
  logic              done_r;

  // Result words; a word that was never written reads as zero.
  logic [WORD_W-1:0] cmem [C_WORDS];
  logic [C_WORDS-1:0] cvalid_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_read_data_r;

  seq_status_t       seq_st;
  logic [CAW-1:0]    seq_wr_idx;
  logic [WORD_W-1:0] seq_wr_data;

  logic           in_fire, is_write, start;
  int             idx;
  logic           hit_ctrl, hit_a, hit_b, hit_c;
  logic [IW-1:0]  a_sel, b_sel;
  logic [CAW-1:0] c_sel;

  // The output register decouples the two sides. While the sequencer is not
  // busy, an item is taken when the register is empty or is being emptied.
  assign in_ready = !seq_st.busy && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign is_write = (op_t'(in_op) == OP_WRITE);

  assign idx      = int'(in_word_index);
  assign hit_ctrl = (in_word_index == CTRL_WORD_IDX);
  assign hit_a    = (idx >= A_BASE) && (idx < B_BASE);
  assign hit_b    = (idx >= B_BASE) && (idx < C_BASE);
  assign hit_c    = (idx >= C_BASE) && (idx < C_BASE + C_WORDS);
  assign a_sel    = IW'(idx - A_BASE);
  assign b_sel    = IW'(idx - B_BASE);
  assign c_sel    = CAW'(idx - C_BASE);
  assign start    = in_fire && is_write && hit_ctrl && in_write_data[CTRL_START_BIT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MATRIX_DIM; i++) begin
        a_rows_r[i] <= '0;
        b_rows_r[i] <= '0;
      end
      done_r <= 1'b0;
    end else if (in_fire && is_write) begin
      if (hit_a) a_rows_r[a_sel] <= in_write_data;
      if (hit_b) b_rows_r[b_sel] <= in_write_data;
      if (start) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= '0;
    end else if (seq_st.wr_en) begin
      cvalid_r[seq_wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_st.wr_en) begin
      cmem[seq_wr_idx] <= seq_wr_data;
    end
  end

  // Read data lands directly in the output register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (is_write) begin
        out_read_data_r <= '0;
      end else if (hit_ctrl) begin
        out_read_data_r <= done_r ? CTRL_DONE : '0;
      end else if (hit_a) begin
        out_read_data_r <= a_rows_r[a_sel];
      end else if (hit_b) begin
        out_read_data_r <= b_rows_r[b_sel];
      end else if (hit_c && cvalid_r[c_sel]) begin
        out_read_data_r <= cmem[c_sel];
      end else begin
        out_read_data_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;

  mm4_mac_seq #(
    .MATRIX_DIM (MATRIX_DIM),
    .ELEM_BITS  (ELEM_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (start),
    .a_rows_i  (a_rows_r),
    .b_rows_i  (b_rows_r),
    .status_o  (seq_st),
    .wr_idx_o  (seq_wr_idx),
    .wr_data_o (seq_wr_data)
  );

endmodule

// ----- rtl/core/mm4_mac_seq.sv -----
module mm4_mac_seq #(
  parameter int  MATRIX_DIM = mm4_pkg::DEF_MATRIX_DIM,
  parameter int  ELEM_BITS  = mm4_pkg::DEF_ELEM_BITS,
  localparam int C_WORDS    = (MATRIX_DIM * MATRIX_DIM + 1) / 2,
  localparam int CAW        = (C_WORDS > 1) ? $clog2(C_WORDS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [mm4_pkg::WORD_W-1:0]  a_rows_i [MATRIX_DIM],
  input  logic [mm4_pkg::WORD_W-1:0]  b_rows_i [MATRIX_DIM],
  output mm4_pkg::seq_status_t        status_o,
  output logic [CAW-1:0]              wr_idx_o,
  output logic [mm4_pkg::WORD_W-1:0]  wr_data_o
);
  import mm4_pkg::*;

  localparam int IW = $clog2(MATRIX_DIM);
  localparam int EW = $clog2(MATRIX_DIM * MATRIX_DIM);
  localparam int PW = 2 * ELEM_BITS;
  localparam logic [IW-1:0] KMAX      = IW'(MATRIX_DIM - 1);
  localparam logic [EW-1:0] ELEM_LAST = EW'(MATRIX_DIM * MATRIX_DIM - 1);

  // Element k of a packed row; elements past bit 31 read as zero.
  function automatic logic [ELEM_BITS-1:0] elem_of(input logic [WORD_W-1:0] row,
                                                   input logic [IW-1:0] k);
    int pos;
    logic [WORD_W-1:0] sh;
    pos = int'(k) * ELEM_BITS;
    sh  = row >> pos;
    if (pos >= WORD_W) return '0;
    return sh[ELEM_BITS-1:0];
  endfunction

  seq_state_t state_r, state_nxt;
  logic [IW-1:0] r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic          issue;
  logic [EW-1:0] elem_cur;

  logic                 s1_vld_r, s1_first_r, s1_last_r;
  logic [EW-1:0]        s1_elem_r;
  logic [ELEM_BITS-1:0] a_op_r, b_op_r;

  logic          s2_vld_r, s2_first_r, s2_last_r;
  logic [EW-1:0] s2_elem_r;
  logic [PW-1:0] prod_r;

  logic [WORD_W-1:0] prod_ext;
  logic [RES_W-1:0]  acc_r, hold_r, acc_sum;

  logic              wr_vld_r;
  logic [CAW-1:0]    wr_idx_r;
  logic [WORD_W-1:0] wr_data_r;

  // Loop order: k fastest, then column, then row.
  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    issue     = 1'b0;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start_i) begin
          state_nxt = SEQ_RUN;
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
        end
      end
      SEQ_RUN: begin
        issue = 1'b1;
        if (k_r == KMAX) begin
          k_nxt = '0;
          if (c_r == KMAX) begin
            c_nxt = '0;
            if (r_r == KMAX) begin
              r_nxt     = '0;
              state_nxt = SEQ_IDLE;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  assign elem_cur = EW'(int'(r_r) * MATRIX_DIM + int'(c_r));

  // Operand fetch, multiply and accumulate each sit behind a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      wr_vld_r <= s2_vld_r && s2_last_r && (s2_elem_r[0] || (s2_elem_r == ELEM_LAST));
    end
  end

  assign prod_ext = WORD_W'(prod_r);
  assign acc_sum  = (s2_first_r ? '0 : acc_r) + prod_ext[RES_W-1:0];

  always_ff @(posedge clk) begin
    a_op_r     <= elem_of(a_rows_i[r_r], k_r);
    b_op_r     <= elem_of(b_rows_i[k_r], c_r);
    s1_first_r <= (k_r == '0);
    s1_last_r  <= (k_r == KMAX);
    s1_elem_r  <= elem_cur;

    prod_r     <= PW'(a_op_r) * PW'(b_op_r);
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_elem_r  <= s1_elem_r;

    if (s2_vld_r) begin
      acc_r <= acc_sum;
      if (s2_last_r && !s2_elem_r[0]) begin
        hold_r <= acc_sum;
      end
    end
    // An even element waits for its odd partner unless it is the last one.
    wr_idx_r  <= CAW'(s2_elem_r >> 1);
    wr_data_r <= s2_elem_r[0] ? {acc_sum, hold_r} : {{RES_W{1'b0}}, acc_sum};
  end

  assign status_o.busy  = (state_r != SEQ_IDLE) || s1_vld_r || s2_vld_r || wr_vld_r;
  assign status_o.wr_en = wr_vld_r;
  assign wr_idx_o       = wr_idx_r;
  assign wr_data_o      = wr_data_r;

endmodule

// ----- rtl/core/mm4_checker.sv -----
module mm4_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_op,
  input logic [4:0]                 in_word_index,
  input logic [mm4_pkg::WORD_W-1:0] in_write_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mm4_pkg::WORD_W-1:0] out_read_data
);
  import mm4_pkg::*;

  logic fire;
  assign fire = in_valid && in_ready;

  // Every accepted item shows its result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("result not presented one cycle after acceptance");

  // A write always answers with zero.
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op_t'(in_op) == OP_WRITE) |=> (out_read_data == '0))
    else $error("write item answered with nonzero data");

  // An accepted start closes the input side right after it.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op_t'(in_op) == OP_WRITE) && (in_word_index == CTRL_WORD_IDX) &&
    in_write_data[CTRL_START_BIT] |=> !in_ready)
    else $error("input accepted right after a start");

  // The control word reads back only the done flag.
  a_ctrl_read: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op_t'(in_op) == OP_READ) && (in_word_index == CTRL_WORD_IDX)
    |=> ((out_read_data & ~CTRL_DONE) == '0))
    else $error("control word read shows bits other than done");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_4x4_regs mm4_checker u_mm4_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .in_word_index (in_word_index),
  .in_write_data (in_write_data),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data)
);
